// ----- design/assr_pkg.sv -----
// Package for the ASCII seven-segment renderer: shared types, segment constants
// and the printable-ASCII glyph lookup. No dependencies.
`timescale 1ns / 1ps

package assr_pkg;

	localparam logic [7:0] NO_GLYPH   = 8'hFF;
	localparam logic [7:0] DP_BIT     = 8'b1000_0000;
	localparam logic [7:0] CODE_PERIOD = 8'h2E;
	localparam logic [7:0] CODE_FIRST  = 8'h20;
	localparam logic [7:0] CODE_LAST   = 8'h7E;
	localparam int         GLYPH_COUNT = 95;

	localparam logic [7:0] GLYPH_TABLE [GLYPH_COUNT] = '{
		8'h00, 8'h86, 8'h22, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'h02,
		8'h39, 8'h0F, 8'hFF, 8'hFF, 8'h08, 8'h40, 8'h80, 8'hFF,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h09, 8'h48, 8'hFF, 8'h48, 8'hFF, 8'h53,
		8'h5F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
		8'h76, 8'h06, 8'h1E, 8'hFF, 8'h38, 8'hFF, 8'h54, 8'h3F,
		8'h73, 8'hFF, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h3E, 8'hFF,
		8'hFF, 8'h6E, 8'h5B, 8'h39, 8'hFF, 8'h0F, 8'hFF, 8'h08,
		8'hFF, 8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h6F,
		8'h74, 8'h04, 8'h0E, 8'hFF, 8'h30, 8'hFF, 8'h54, 8'h5C,
		8'h73, 8'hFF, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1C, 8'hFF,
		8'hFF, 8'h6E, 8'hFF, 8'h39, 8'h06, 8'h0F, 8'h63
	};

	typedef struct packed {
		logic [3:0] next_position;
		logic [3:0] string_origin;
		logic [7:0] previous_glyph;
		logic       halted;
	} render_state_t;

	typedef struct packed {
		logic       write_enable;
		logic [3:0] write_position;
		logic [7:0] segment_byte;
		logic       unknown_glyph;
		logic       overflow;
		logic [3:0] chars_written;
	} render_result_t;

	function automatic logic [7:0] lookup_glyph(input logic [7:0] code);
		logic [7:0] offset;
		begin
			offset = code - CODE_FIRST;
			if (code < CODE_FIRST || code > CODE_LAST) begin
				lookup_glyph = NO_GLYPH;
			end else begin
				lookup_glyph = GLYPH_TABLE[offset[6:0]];
			end
		end
	endfunction

endpackage

// ----- design/assr_step.sv -----
// One character step of the renderer: glyph lookup, period handling, overflow
// and the position update. Depends on assr_pkg.
`timescale 1ns / 1ps

module assr_step
	import assr_pkg::*;
(
	input  render_state_t  cur_state,
	input  logic [3:0]     limit,
	input  logic [7:0]     char_code,
	input  logic           first_char,
	input  logic [3:0]     start_position,
	output render_state_t  nxt_state,
	output render_result_t result
);

	render_state_t st;
	logic [7:0]    glyph;

	always_comb begin
		st = cur_state;
		if (first_char) begin
			st.string_origin  = start_position;
			st.next_position  = start_position;
			st.previous_glyph = '0;
			st.halted         = 1'b0;
		end

		glyph                 = lookup_glyph(char_code);
		result.write_enable   = 1'b0;
		result.write_position = '0;
		result.segment_byte   = '0;
		result.unknown_glyph  = 1'b0;

		if (!st.halted) begin
			if (char_code == CODE_PERIOD) begin
				if (st.next_position > st.string_origin) begin
					st.previous_glyph     = st.previous_glyph | DP_BIT;
					result.write_enable   = 1'b1;
					result.write_position = st.next_position - 4'd1;
					result.segment_byte   = st.previous_glyph;
				end
			end else begin
				result.unknown_glyph = (glyph == NO_GLYPH);
				if (st.next_position >= limit) begin
					st.halted = 1'b1;
				end else begin
					result.write_enable   = 1'b1;
					result.write_position = st.next_position;
					result.segment_byte   = glyph;
					st.previous_glyph     = glyph;
					st.next_position      = st.next_position + 4'd1;
				end
			end
		end

		result.overflow      = st.halted;
		result.chars_written = st.next_position - st.string_origin;
		nxt_state            = st;
	end

endmodule

// ----- design/ascii_seven_segment_renderer_core.sv -----
// Top level of the ASCII seven-segment renderer: input register, step logic and
// result register. Depends on assr_pkg and assr_step.
//
// Usage: characters arrive on the input channel (in_valid/in_ready) with
// char_code, first_char and start_position. Each request yields exactly one
// result on the output channel (out_valid/out_ready): an optional digit-buffer
// write, the unknown_glyph and overflow flags, and chars_written.
// The request sits in the input register, and the glyph lookup and position
// update load the result register from it when the request advances.
// Throughput is one character per cycle while the receiver does not stall, set
// by the single step unit that updates the string state once per character.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are occupied and out_ready is low.
// The user must write active_digits through cfg_write_enable/cfg_write_data
// only while the block is idle (unenforced); the limit clamps to MAX_DIGITS.
// Reset clears both valid flags and the string state (next string at digit 0)
// and sets active_digits to 12.
`timescale 1ns / 1ps

module ascii_seven_segment_renderer_core
	import assr_pkg::*;
#(
	parameter int MAX_DIGITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_enable,
	input  logic [3:0] cfg_write_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       first_char,
	input  logic [3:0] start_position,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       write_enable,
	output logic [3:0] write_position,
	output logic [7:0] segment_byte,
	output logic       unknown_glyph,
	output logic       overflow,
	output logic [3:0] chars_written
);

	localparam logic [3:0] MaxLimit = 4'(MAX_DIGITS);

	logic [3:0]     active_digits_q;
	logic [3:0]     limit;
	render_state_t  state_q;
	render_state_t  state_nxt;
	render_result_t result_nxt;
	render_result_t result_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic [7:0]     char_code_s1;
	logic           first_char_s1;
	logic [3:0]     start_position_s1;
	logic           advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign limit    = (active_digits_q > MaxLimit) ? MaxLimit : active_digits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_digits_q <= 4'd12;
		end else if (cfg_write_enable) begin
			active_digits_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_code_s1      <= char_code;
			first_char_s1     <= first_char;
			start_position_s1 <= start_position;
		end
	end

	assr_step u_step (
		.cur_state      (state_q),
		.limit          (limit),
		.char_code      (char_code_s1),
		.first_char     (first_char_s1),
		.start_position (start_position_s1),
		.nxt_state      (state_nxt),
		.result         (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid      = valid_s2;
	assign write_enable   = result_s2.write_enable;
	assign write_position = result_s2.write_position;
	assign segment_byte   = result_s2.segment_byte;
	assign unknown_glyph  = result_s2.unknown_glyph;
	assign overflow       = result_s2.overflow;
	assign chars_written  = result_s2.chars_written;

	a_overflow_no_write : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !write_enable)
		else $error("overflowed request produced a buffer write");

	a_idle_fields_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> segment_byte == 8'h00 && write_position == 4'd0)
		else $error("result without write carries nonzero position or pattern");

	a_unknown_pattern : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unknown_glyph && write_enable |-> segment_byte == NO_GLYPH)
		else $error("unknown glyph written with a pattern other than all segments");

	a_stage1_holds : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_code_s1))
		else $error("input register lost a stalled request");

	a_state_on_advance : assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("string state changed without a request passing");

endmodule
